FILE: hdl/parallel_port_sound_fifo_unit_assert.svh
// assertion macros for the parallel port sound fifo unit
// used by modules that check their own logic; expects clk and rst in scope
`ifndef PARALLEL_PORT_SOUND_FIFO_UNIT_ASSERT_SVH
`define PARALLEL_PORT_SOUND_FIFO_UNIT_ASSERT_SVH

// condition that must hold at every clock edge out of reset
`define PSF_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define PSF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/psf_pkg.sv
// shared types, codes and constants of the parallel port sound fifo unit
// no dependencies
package psf_pkg;

  localparam int FIFO_DEPTH = 16;
  localparam int IDX_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // item kinds
  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;

  localparam logic [15:0] BASE_PORT_RESET = 16'h0378;
  localparam logic [15:0] CTRL_OFFSET     = 16'd2;
  localparam logic [7:0]  STATUS_BUSY     = 8'h40;
  localparam logic [7:0]  CTRL_POWER_ON   = 8'h04;
  localparam int          CTRL_OFF_BIT    = 3;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] port;
    logic [7:0]  data;
  } psf_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] sample;
  } psf_out_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic       clear;
    logic [7:0] data;
  } psf_fifo_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } psf_fifo_stat_t;

endpackage

FILE: hdl/psf_fifo.sv
// sample fifo: storage, indices, fill count and registered pop data
// depends on psf_pkg and parallel_port_sound_fifo_unit_assert.svh
`include "parallel_port_sound_fifo_unit_assert.svh"

module psf_fifo (
  input  logic                   clk,
  input  logic                   rst,
  input  psf_pkg::psf_fifo_cmd_t cmd,
  output psf_pkg::psf_fifo_stat_t stat,
  output logic [7:0]             sample
);

  logic [7:0]               store [psf_pkg::FIFO_DEPTH];
  logic [psf_pkg::IDX_W-1:0] write_index;
  logic [psf_pkg::IDX_W-1:0] read_index;
  logic [psf_pkg::CNT_W-1:0] fill_count;

  function automatic logic [psf_pkg::IDX_W-1:0] wrap_inc(input logic [psf_pkg::IDX_W-1:0] i);
    return (i == psf_pkg::IDX_W'(psf_pkg::FIFO_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  assign stat.full  = (fill_count == psf_pkg::CNT_W'(psf_pkg::FIFO_DEPTH));
  assign stat.empty = (fill_count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      write_index <= '0;
      read_index  <= '0;
      fill_count  <= '0;
    end else if (cmd.clear) begin
      write_index <= '0;
      read_index  <= '0;
      fill_count  <= '0;
    end else if (cmd.push) begin
      write_index <= wrap_inc(write_index);
      fill_count  <= fill_count + 1'b1;
    end else if (cmd.pop) begin
      read_index <= wrap_inc(read_index);
      fill_count <= fill_count - 1'b1;
    end
  end

  // storage write port
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      store[write_index] <= cmd.data;
    end
  end

  // registered read, zero when nothing is popped
  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      sample <= store[read_index];
    end else begin
      sample <= '0;
    end
  end

  `PSF_ASSERT_ALWAYS(a_count_range, fill_count <= psf_pkg::CNT_W'(psf_pkg::FIFO_DEPTH), "fill count beyond depth")
  `PSF_ASSERT_ALWAYS(a_no_push_full, !(cmd.push && stat.full), "push into full fifo")
  `PSF_ASSERT_ALWAYS(a_no_pop_empty, !(cmd.pop && stat.empty), "pop from empty fifo")
  `PSF_ASSERT_NEXT(a_clear_empties, cmd.clear, fill_count == '0 && read_index == write_index, "clear left data")
  `PSF_ASSERT_NEXT(a_push_counts, cmd.push && !cmd.clear, fill_count == $past(fill_count) + 1'b1, "push miscounted")

endmodule

FILE: hdl/psf_ctrl.sv
// item decode, power state and status byte
// depends on psf_pkg
module psf_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    item_valid,
  input  psf_pkg::psf_in_t        item,
  input  logic [15:0]             base_port,
  input  psf_pkg::psf_fifo_stat_t stat,
  output psf_pkg::psf_fifo_cmd_t  cmd,
  output logic [7:0]              read_data_next
);

  logic        powered;
  logic        powered_next;
  logic [15:0] ctrl_port;
  logic        is_write;
  logic        data_hit;
  logic        ctrl_hit;
  logic        power_on;
  logic        power_off;

  assign ctrl_port = base_port + psf_pkg::CTRL_OFFSET;
  assign is_write  = item_valid && (item.func == psf_pkg::FUNC_WRITE);
  assign data_hit  = is_write && (item.port == base_port);
  assign ctrl_hit  = is_write && !data_hit && (item.port == ctrl_port);
  assign power_on  = ctrl_hit && (item.data == psf_pkg::CTRL_POWER_ON) && !powered;
  assign power_off = ctrl_hit && item.data[psf_pkg::CTRL_OFF_BIT] && powered;

  always_comb begin
    powered_next = powered;
    if (power_on) begin
      powered_next = 1'b1;
    end else if (power_off) begin
      powered_next = 1'b0;
    end
  end

  always_comb begin
    cmd.clear = power_on;
    cmd.push  = data_hit && powered && !stat.full;
    cmd.pop   = item_valid && (item.func == psf_pkg::FUNC_TICK) && powered && !stat.empty;
    cmd.data  = item.data;
    read_data_next = '0;
    if (item_valid && (item.func == psf_pkg::FUNC_READ) && (!powered || stat.full)) begin
      read_data_next = psf_pkg::STATUS_BUSY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      powered <= 1'b0;
    end else begin
      powered <= powered_next;
    end
  end

endmodule

FILE: hdl/parallel_port_sound_fifo_unit.sv
// top level of the parallel port sound fifo unit
// depends on psf_pkg, psf_ctrl and psf_fifo
//
// usage:
//   command channel: drive cmd and raise start; the word is taken at any
//   rising edge with start high and busy low. busy never rises, so a new
//   word (port write, port read or sample tick) can enter every cycle.
//   result channel: every accepted word yields exactly one result word,
//   shown on result while done is high for one cycle. read_data carries
//   the status byte of a read, sample the byte popped by a tick; both are
//   zero where they do not apply.
//   path: the word is captured in the input register (item_valid, item),
//   decoded, and applied to the fifo at the edge that also loads the
//   result register (done, read_data) and the fifo's sample register;
//   done then marks the result word on result.
//   throughput is one word per cycle; all decode and fifo updates sit in
//   a single stage between the input and result registers.
//   configuration: cfg_data sets the data port address (control port is
//   that plus two); cfg_ready is always high, write it only while idle.
//   reset: rst clears the device to off with an empty fifo, base port
//   back to 0x378, no word pending. the receiver cannot stall results.
module parallel_port_sound_fifo_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  psf_pkg::psf_in_t  cmd,
  output logic              done,
  output psf_pkg::psf_out_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [15:0]       cfg_data
);

  logic                    item_valid;
  psf_pkg::psf_in_t        item;
  logic [15:0]             base_port;
  psf_pkg::psf_fifo_cmd_t  fifo_cmd;
  psf_pkg::psf_fifo_stat_t fifo_stat;
  logic [7:0]              read_data_next;
  logic [7:0]              read_data;
  logic [7:0]              sample;

  // the single stage never holds off a word
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // base port register
  always_ff @(posedge clk) begin
    if (rst) begin
      base_port <= psf_pkg::BASE_PORT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      base_port <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    item <= cmd;
  end

  psf_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item           (item),
    .base_port      (base_port),
    .stat           (fifo_stat),
    .cmd            (fifo_cmd),
    .read_data_next (read_data_next)
  );

  // sample comes out of the fifo already registered alongside read_data
  psf_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .cmd    (fifo_cmd),
    .stat   (fifo_stat),
    .sample (sample)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    read_data <= read_data_next;
  end

  assign result.read_data = read_data;
  assign result.sample    = sample;

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// self-checking bench for parallel_port_sound_fifo_unit: port writes, status reads, sample ticks
// depends on psf_pkg and the unit's rtl; predicts every result word and checks it in order
module tb_top;

  // the func code that the unit leaves unused
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // time to settle once every queued result word is back
  localparam int SETTLE_CYCLES = 4;
  localparam int IDLE_PERCENT  = 29;
  localparam int REPORT_LIMIT  = 10;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              start     = 1'b0;
  logic              busy;
  psf_pkg::psf_in_t  cmd       = '0;
  logic              done;
  psf_pkg::psf_out_t result;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [15:0]       cfg_data  = '0;

  parallel_port_sound_fifo_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // words waiting to be sent and result words still owed by the unit
  psf_pkg::psf_in_t  pending_words[$];
  psf_pkg::psf_out_t expected_words[$];
  int                mismatch_count = 0;

  // sender runs without gaps while this is set
  bit          steady_sender = 1'b0;
  // data port the stimulus aims at in the current phase
  logic [15:0] phase_base    = psf_pkg::BASE_PORT_RESET;

  // shadow of the device: base port, sample ring, indices, fill level, power
  logic [15:0]               dev_base = psf_pkg::BASE_PORT_RESET;
  logic [7:0]                dev_ring [psf_pkg::FIFO_DEPTH];
  logic [psf_pkg::IDX_W-1:0] dev_wr   = '0;
  logic [psf_pkg::IDX_W-1:0] dev_rd   = '0;
  logic [psf_pkg::CNT_W-1:0] dev_fill = '0;
  logic                      dev_on   = 1'b0;

  initial begin
    foreach (dev_ring[i]) dev_ring[i] = '0;
  end

  // advance the shadow device by one accepted word and queue the result it owes
  task automatic apply_sound_cmd(input psf_pkg::psf_in_t c);
    psf_pkg::psf_out_t r;
    logic [15:0]       ctrl_port;
    r = '0;
    ctrl_port = dev_base + psf_pkg::CTRL_OFFSET;  // wraps at 16 bits
    case (c.func)
      psf_pkg::FUNC_WRITE: begin
        if (c.port == dev_base) begin
          // bytes are dropped while off or full
          if (dev_on && dev_fill < psf_pkg::FIFO_DEPTH) begin
            dev_ring[dev_wr] = c.data;
            dev_wr = (dev_wr == psf_pkg::FIFO_DEPTH - 1) ? '0 : dev_wr + 1'b1;
            dev_fill = dev_fill + 1'b1;
          end
        end else if (c.port == ctrl_port) begin
          if (c.data == psf_pkg::CTRL_POWER_ON && !dev_on) begin
            // power on empties the ring; old bytes become unreachable
            dev_wr   = '0;
            dev_rd   = '0;
            dev_fill = '0;
            dev_on   = 1'b1;
          end else if (c.data[psf_pkg::CTRL_OFF_BIT] && dev_on) begin
            dev_on = 1'b0;
          end
        end
      end
      psf_pkg::FUNC_READ: begin
        r.read_data = (!dev_on || dev_fill == psf_pkg::FIFO_DEPTH) ?
                      psf_pkg::STATUS_BUSY : 8'h00;
      end
      psf_pkg::FUNC_TICK: begin
        if (dev_on && dev_fill != 0) begin
          r.sample = dev_ring[dev_rd];
          dev_rd = (dev_rd == psf_pkg::FIFO_DEPTH - 1) ? '0 : dev_rd + 1'b1;
          dev_fill = dev_fill - 1'b1;
        end
      end
      default: ;  // unused code: no effect, both fields zero
    endcase
    expected_words.push_back(r);
  endtask

  // driver: a word leaves when start is high and busy low at the edge;
  // start is assigned once per edge so a back-to-back word never drops it
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (start) apply_sound_cmd(cmd);
      if (pending_words.size() != 0 &&
          (steady_sender || $urandom_range(99) >= IDLE_PERCENT)) begin
        start <= 1'b1;
        cmd   <= pending_words.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: done marks a result word for exactly one cycle, no backpressure
  always @(posedge clk) begin
    psf_pkg::psf_out_t want;
    if (!rst && done) begin
      if (expected_words.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected result word: read_data=%h sample=%h",
                   result.read_data, result.sample);
      end else begin
        want = expected_words.pop_front();
        if (result.read_data !== want.read_data || result.sample !== want.sample) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("result mismatch: read_data exp %h got %h, sample exp %h got %h",
                     want.read_data, result.read_data, want.sample, result.sample);
        end
      end
    end
  end

  task automatic queue_cmd(input logic [1:0] f, input logic [15:0] p, input logic [7:0] d);
    psf_pkg::psf_in_t c;
    c.func = f;
    c.port = p;
    c.data = d;
    pending_words.push_back(c);
  endtask

  // reads and ticks carry random port and data, which the unit must ignore
  task automatic queue_read();
    queue_cmd(psf_pkg::FUNC_READ, 16'($urandom), 8'($urandom));
  endtask

  task automatic queue_tick();
    queue_cmd(psf_pkg::FUNC_TICK, 16'($urandom), 8'($urandom));
  endtask

  // random traffic in bursts: fills and drains push the ring to full and
  // empty, power changes are rare so the device is mostly on
  task automatic queue_traffic(input int n);
    int          start_size;
    int          k;
    int          pick;
    logic [15:0] ctrl_port;
    logic [7:0]  d;
    start_size = pending_words.size();
    ctrl_port  = phase_base + psf_pkg::CTRL_OFFSET;
    while (pending_words.size() - start_size < n) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        // fill burst, long enough to overrun the ring
        k = $urandom_range(1, 20);
        repeat (k) begin
          queue_cmd(psf_pkg::FUNC_WRITE, phase_base, 8'($urandom));
          if ($urandom_range(7) == 0) queue_read();
        end
      end else if (pick < 60) begin
        // drain burst, long enough to tick an empty ring
        k = $urandom_range(1, 20);
        repeat (k) begin
          queue_tick();
          if ($urandom_range(7) == 0) queue_read();
        end
      end else if (pick < 80) begin
        k = $urandom_range(4, 24);
        repeat (k) begin
          case ($urandom_range(2))
            0: queue_cmd(psf_pkg::FUNC_WRITE, phase_base, 8'($urandom));
            1: queue_tick();
            default: queue_read();
          endcase
        end
      end else if (pick < 88) begin
        queue_cmd(psf_pkg::FUNC_WRITE, ctrl_port, psf_pkg::CTRL_POWER_ON);
      end else if (pick < 92) begin
        d = 8'($urandom);
        d[psf_pkg::CTRL_OFF_BIT] = 1'b1;
        queue_cmd(psf_pkg::FUNC_WRITE, ctrl_port, d);
      end else if (pick < 95) begin
        // control byte without the off bit; usually not the power-on code
        d = 8'($urandom);
        d[psf_pkg::CTRL_OFF_BIT] = 1'b0;
        queue_cmd(psf_pkg::FUNC_WRITE, ctrl_port, d);
      end else begin
        // noise: stray port writes and the unused code
        queue_cmd(psf_pkg::FUNC_WRITE, 16'($urandom), 8'($urandom));
        queue_cmd(FUNC_UNUSED, 16'($urandom), 8'($urandom));
      end
    end
  endtask

  // wait until every queued word is sent and every result word is back
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_words.size() != 0 || start || expected_words.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write the base port while the unit is idle
  task automatic write_base(input logic [15:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk);
    while (!cfg_ready);
    dev_base   = v;
    phase_base = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [15:0] base, input int n, input bit steady);
    write_base(base);
    steady_sender = steady;
    queue_traffic(n);
    wait_drained();
  endtask

  initial begin
    logic [15:0] ctrl_port;
    logic [15:0] data_port;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed part at the reset base port
    data_port = psf_pkg::BASE_PORT_RESET;
    ctrl_port = psf_pkg::BASE_PORT_RESET + psf_pkg::CTRL_OFFSET;
    queue_cmd(psf_pkg::FUNC_READ, 16'hFFFF, 8'hFF);                 // off: status busy
    queue_cmd(psf_pkg::FUNC_TICK, 16'h0000, 8'h00);                 // off: sample zero
    queue_cmd(psf_pkg::FUNC_WRITE, data_port, 8'hA5);               // off: byte dropped
    queue_cmd(psf_pkg::FUNC_WRITE, ctrl_port, 8'h08);               // off bit while off
    queue_cmd(psf_pkg::FUNC_WRITE, ctrl_port, psf_pkg::CTRL_POWER_ON);  // power on
    queue_cmd(psf_pkg::FUNC_READ, 16'h0000, 8'h00);                 // on and empty
    queue_cmd(psf_pkg::FUNC_TICK, 16'hFFFF, 8'hFF);                 // tick on empty ring
    queue_cmd(psf_pkg::FUNC_WRITE, data_port, 8'hFF);
    queue_cmd(psf_pkg::FUNC_WRITE, data_port, 8'h00);
    // power on while on
    queue_cmd(psf_pkg::FUNC_WRITE, ctrl_port, psf_pkg::CTRL_POWER_ON);
    queue_cmd(psf_pkg::FUNC_TICK, 16'h0000, 8'h00);
    queue_cmd(psf_pkg::FUNC_TICK, 16'h0000, 8'h00);
    queue_cmd(psf_pkg::FUNC_WRITE, data_port + 1'b1, 8'h5A);        // stray port
    queue_cmd(psf_pkg::FUNC_WRITE, 16'hFFFF, 8'hFF);
    queue_cmd(FUNC_UNUSED, 16'hFFFF, 8'hFF);
    queue_cmd(psf_pkg::FUNC_WRITE, ctrl_port, 8'h05);               // other control byte
    queue_cmd(psf_pkg::FUNC_WRITE, data_port, 8'h3C);
    queue_cmd(psf_pkg::FUNC_WRITE, ctrl_port, 8'hFF);               // power off, byte kept
    queue_cmd(psf_pkg::FUNC_TICK, 16'h0000, 8'h00);                 // off: sample zero
    queue_cmd(psf_pkg::FUNC_READ, 16'h0000, 8'h00);
    // power on empties ring
    queue_cmd(psf_pkg::FUNC_WRITE, ctrl_port, psf_pkg::CTRL_POWER_ON);
    queue_cmd(psf_pkg::FUNC_TICK, 16'h0000, 8'h00);
    // power on while already on, before the random part
    queue_cmd(psf_pkg::FUNC_WRITE, ctrl_port, psf_pkg::CTRL_POWER_ON);
    queue_traffic(300);
    wait_drained();

    // base port settings, extremes included; one phase with a steady sender.
    // with the top base the control port wraps around to port one
    run_phase(16'h0000, 300, 1'b0);
    run_phase(16'hFFFF, 300, 1'b1);
    run_phase(16'hFFFE, 250, 1'b0);
    run_phase(16'($urandom), 250, 1'b0);
    run_phase(psf_pkg::BASE_PORT_RESET, 200, 1'b0);

    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // guard against a hung handshake
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
